// File: rtl/mm64_pkg.sv
package mm64_pkg;

    localparam int WORD_W    = 64;
    localparam int NBYTES_W  = 4;
    localparam int KLEN_W    = 32;
    localparam int HALF_W    = WORD_W / 2;
    localparam int BYTES_PER_WORD = WORD_W / 8;

    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int                MIX_SHIFT  = 47;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'd5381;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = PADDR_W - 3;
    localparam logic [REG_IDX_W-1:0] REG_HASH_SEED = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_KEY1,
        S_KEY2,
        S_HASH,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } t_mul_rsp;

endpackage

// File: rtl/mm64_if.sv
interface mm64_key_if;
    import mm64_pkg::*;

    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   key_word;
    logic [NBYTES_W-1:0] word_bytes;
    logic [KLEN_W-1:0]   key_length;
    logic                first_word;
    logic                last_word;

    modport source (
        output valid, key_word, word_bytes, key_length, first_word, last_word,
        input  ready
    );
    modport sink (
        input  valid, key_word, word_bytes, key_length, first_word, last_word,
        output ready
    );
endinterface

interface mm64_hash_if;
    import mm64_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

// File: rtl/mm64_mul.sv
module mm64_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mm64_pkg::t_mul_req  i_req,
    output mm64_pkg::t_mul_rsp  o_rsp
);
    import mm64_pkg::*;

    localparam logic [1:0] STEP_LO_LO = 2'd0;
    localparam logic [1:0] STEP_LO_HI = 2'd1;
    localparam logic [1:0] STEP_HI_LO = 2'd2;

    logic              r_busy;
    logic [1:0]        r_step;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_acc;
    logic              r_done;

    logic [HALF_W-1:0] op_a;
    logic [HALF_W-1:0] op_b;
    logic [WORD_W-1:0] prod;

    // partial products of a * MIX_MUL, low 64 bits only
    always_comb begin
        case (r_step)
            STEP_LO_LO: begin
                op_a = r_a[HALF_W-1:0];
                op_b = MIX_MUL[HALF_W-1:0];
            end
            STEP_LO_HI: begin
                op_a = r_a[HALF_W-1:0];
                op_b = MIX_MUL[WORD_W-1:HALF_W];
            end
            STEP_HI_LO: begin
                op_a = r_a[WORD_W-1:HALF_W];
                op_b = MIX_MUL[HALF_W-1:0];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_LO_LO;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LO_LO;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == STEP_HI_LO) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end else if (r_busy) begin
            if (r_step == STEP_LO_LO) begin
                r_acc <= prod;
            end else begin
                r_acc[WORD_W-1:HALF_W] <= r_acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// File: rtl/mm64_cfg.sv
module mm64_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mm64_pkg::PADDR_W-1:0]  paddr,
    input  logic [mm64_pkg::PDATA_W-1:0]  pwdata,
    output logic [mm64_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [mm64_pkg::WORD_W-1:0]   o_seed
);
    import mm64_pkg::*;

    logic [WORD_W-1:0]    r_seed;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_HASH_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (wr_en) begin
            r_seed <= pwdata;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HASH_SEED: prdata = r_seed;
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_seed = r_seed;

endmodule

// File: rtl/mm64_ctrl.sv
module mm64_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mm64_pkg::WORD_W-1:0]    i_seed,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mm64_pkg::WORD_W-1:0]    i_key_word,
    input  logic [mm64_pkg::NBYTES_W-1:0]  i_word_bytes,
    input  logic [mm64_pkg::KLEN_W-1:0]    i_key_length,
    input  logic                           i_first_word,
    input  logic                           i_last_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mm64_pkg::WORD_W-1:0]    o_hash_value,
    output mm64_pkg::t_mul_req             o_mul_req,
    input  mm64_pkg::t_mul_rsp             i_mul_rsp
);
    import mm64_pkg::*;

    localparam logic [NBYTES_W-1:0] FULL_BYTES = NBYTES_W'(BYTES_PER_WORD);

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_hash, n_hash;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [NBYTES_W-1:0] r_nb, n_nb;
    logic                r_last, n_last;
    logic [WORD_W-1:0]   r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_hash, n_out_hash;

    logic [NBYTES_W-1:0] in_nb;
    logic [WORD_W-1:0]   in_masked;
    logic [WORD_W-1:0]   cur_word;
    logic [NBYTES_W-1:0] cur_nb;
    logic                cur_last;
    logic                go_tail;
    logic [WORD_W-1:0]   tail_h;
    logic                go_end;
    logic [WORD_W-1:0]   end_h;
    logic [WORD_W-1:0]   fin_res;

    // byte count clamp and masking of bytes beyond the count
    always_comb begin
        in_nb = (i_word_bytes > FULL_BYTES) ? FULL_BYTES : i_word_bytes;
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            in_masked[8*i +: 8] = (NBYTES_W'(i) < in_nb) ? i_key_word[8*i +: 8] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_nb       <= n_nb;
        r_last     <= n_last;
        r_res      <= n_res;
        r_out_hash <= n_out_hash;
    end

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_word      = r_word;
        n_nb        = r_nb;
        n_last      = r_last;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_hash  = r_out_hash;
        o_mul_req   = '0;
        go_tail     = 1'b0;
        tail_h      = r_hash;
        go_end      = 1'b0;
        end_h       = r_hash;
        fin_res     = xorshift(i_mul_rsp.product);

        cur_word = (r_state == S_IDLE) ? in_masked   : r_word;
        cur_nb   = (r_state == S_IDLE) ? in_nb       : r_nb;
        cur_last = (r_state == S_IDLE) ? i_last_word : r_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_word = in_masked;
                    n_nb   = in_nb;
                    n_last = i_last_word;
                    if (i_first_word) begin
                        n_state           = S_LEN;
                        o_mul_req.start   = 1'b1;
                        o_mul_req.operand = {{(WORD_W-KLEN_W){1'b0}}, i_key_length};
                    end else begin
                        go_tail = 1'b1;
                        tail_h  = r_hash;
                    end
                end
            end
            S_LEN: begin
                if (i_mul_rsp.done) begin
                    go_tail = 1'b1;
                    tail_h  = i_seed ^ i_mul_rsp.product;
                end
            end
            S_KEY1: begin
                if (i_mul_rsp.done) begin
                    n_state           = S_KEY2;
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = xorshift(i_mul_rsp.product);
                end
            end
            S_KEY2: begin
                if (i_mul_rsp.done) begin
                    n_state           = S_HASH;
                    o_mul_req.start   = 1'b1;
                    o_mul_req.operand = r_hash ^ i_mul_rsp.product;
                end
            end
            S_HASH: begin
                if (i_mul_rsp.done) begin
                    go_end = 1'b1;
                    end_h  = i_mul_rsp.product;
                end
            end
            S_FIN: begin
                if (i_mul_rsp.done) begin
                    if (!r_out_valid || i_out_ready) begin
                        n_out_valid = 1'b1;
                        n_out_hash  = fin_res;
                        n_state     = S_IDLE;
                    end else begin
                        n_res   = fin_res;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // full word mix, tail bytes, or nothing
        if (go_tail) begin
            n_hash = tail_h;
            if (cur_nb == FULL_BYTES) begin
                n_state           = S_KEY1;
                o_mul_req.start   = 1'b1;
                o_mul_req.operand = cur_word;
            end else if (cur_nb != '0) begin
                n_state           = S_HASH;
                o_mul_req.start   = 1'b1;
                o_mul_req.operand = tail_h ^ cur_word;
            end else begin
                go_end = 1'b1;
                end_h  = tail_h;
            end
        end

        if (go_end) begin
            n_hash = end_h;
            if (cur_last) begin
                n_state           = S_FIN;
                o_mul_req.start   = 1'b1;
                o_mul_req.operand = xorshift(end_h);
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule

// File: rtl/murmur64a_key_hash.sv
// murmurhash64a key hasher
//
// i_key takes a key as a stream of 64-bit little-endian words; first_word
// starts a new hash seeded with hash_seed xor (key_length * multiplier),
// last_word closes the key and runs the finalizer. o_hash carries one
// 64-bit hash per key, only for the transaction with last_word set.
// hash_seed is written over the apb port at byte address 0; the user must
// write it only while idle, and the block itself does not enforce that.
//
// every 64-bit multiply runs on one shared 32x32 multiplier that hands the
// product back with a done strobe; a transaction holds the input for each
// multiply it needs: 1 for the key length seed (first word), 3 for a full
// word, 1 for a tail, 1 for the finalizer. a word needing none returns
// ready at once; the hash shows in the same cycle that ready returns.
//
// reset clears the running hash, drops o_hash.valid and sets the seed to
// 5381. the finished hash sits in an output register; while the receiver
// stalls the next key words are still taken, and only a second finished
// hash waits inside until the register frees up.
module murmur64a_key_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mm64_key_if.sink                      i_key,
    mm64_hash_if.source                   o_hash,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mm64_pkg::PADDR_W-1:0]  paddr,
    input  logic [mm64_pkg::PDATA_W-1:0]  pwdata,
    output logic [mm64_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mm64_pkg::*;

    logic [WORD_W-1:0] seed;
    t_mul_req          mul_req;
    t_mul_rsp          mul_rsp;

    mm64_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seed  (seed)
    );

    mm64_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (seed),
        .i_valid      (i_key.valid),
        .o_ready      (i_key.ready),
        .i_key_word   (i_key.key_word),
        .i_word_bytes (i_key.word_bytes),
        .i_key_length (i_key.key_length),
        .i_first_word (i_key.first_word),
        .i_last_word  (i_key.last_word),
        .o_out_valid  (o_hash.valid),
        .i_out_ready  (o_hash.ready),
        .o_hash_value (o_hash.hash_value),
        .o_mul_req    (mul_req),
        .i_mul_rsp    (mul_rsp)
    );

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

endmodule

// File: rtl/mm64_chk.sv
module mm64_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_first,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [mm64_pkg::WORD_W-1:0]  out_hash
);
    import mm64_pkg::*;

    // a first word always runs the length multiply
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready && in_first) |=> !in_ready)
        else $error("input ready stayed high after a first word transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_hash)))
        else $error("stalled hash changed or vanished");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("hash valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> in_ready)
        else $error("input not ready after reset");

endmodule

bind murmur64a_key_hash mm64_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_key.valid),
    .in_ready  (i_key.ready),
    .in_first  (i_key.first_word),
    .out_valid (o_hash.valid),
    .out_ready (o_hash.ready),
    .out_hash  (o_hash.hash_value)
);

// File: test/murmur64a_key_hash_tb.sv
`timescale 1ns / 100ps

module murmur64a_key_hash_tb;
    import mm64_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 230;
    localparam int MAX_REPORTS  = 10;
    localparam logic [PADDR_W-1:0] SEED_ADDR = {REG_HASH_SEED, 3'b000};

    typedef struct packed {
        logic [WORD_W-1:0]   key_word;
        logic [NBYTES_W-1:0] word_bytes;
        logic [KLEN_W-1:0]   key_length;
        logic                first_word;
        logic                last_word;
    } t_key_beat;

    typedef struct packed {
        logic              reseed;
        logic [WORD_W-1:0] seed;
        t_key_beat         beat;
        logic              fixed;
        logic [WORD_W-1:0] fixed_hash;
    } t_dir_row;

    localparam int DIR_ROWS = 23;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // continuation right after reset, empty tail
        '{1'b0, 64'd0, '{64'd0, 4'd0, 32'd0, 1'b0, 1'b1}, 1'b1, 64'd0},
        // empty key at reset seed
        '{1'b0, 64'd0, '{64'd0, 4'd0, 32'd0, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{ONES, 4'd8, 32'd8, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'd0, 4'd8, 32'hffff_ffff, 1'b1, 1'b1}, 1'b0, 64'd0},
        // oversized byte counts
        '{1'b0, 64'd0, '{64'h0123_4567_89ab_cdef, 4'd15, 32'd8, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'hfedc_ba98_7654_3210, 4'd9, 32'd8, 1'b1, 1'b1}, 1'b0, 64'd0},
        // three word key
        '{1'b0, 64'd0, '{64'ha5a5_a5a5_a5a5_a5a5, 4'd8, 32'd19, 1'b1, 1'b0}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'h5a5a_5a5a_5a5a_5a5a, 4'd8, 32'd0, 1'b0, 1'b0}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'h0011_2233_4455_6677, 4'd3, 32'd0, 1'b0, 1'b1}, 1'b0, 64'd0},
        // short word that is not last
        '{1'b0, 64'd0, '{64'h8899_aabb_ccdd_eeff, 4'd5, 32'd13, 1'b1, 1'b0}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'h1357_9bdf_2468_ace0, 4'd8, 32'd0, 1'b0, 1'b1}, 1'b0, 64'd0},
        // continuation after a finished key
        '{1'b0, 64'd0, '{64'hdead_beef_cafe_f00d, 4'd8, 32'd0, 1'b0, 1'b1}, 1'b0, 64'd0},
        // bytes beyond the count
        '{1'b0, 64'd0, '{ONES, 4'd1, 32'd1, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'h7766_5544_3322_1100, 4'd7, 32'd7, 1'b1, 1'b1}, 1'b0, 64'd0},
        // length mismatch
        '{1'b0, 64'd0, '{64'h8000_0000_0000_0001, 4'd4, 32'd100, 1'b1, 1'b1}, 1'b0, 64'd0},
        // zero seed, zero length: everything stays zero
        '{1'b1, 64'd0, '{64'd0, 4'd0, 32'd0, 1'b1, 1'b1}, 1'b1, 64'd0},
        '{1'b0, 64'd0, '{64'hffff_ffff_ffff_ff00, 4'd1, 32'd0, 1'b1, 1'b1}, 1'b1, 64'd0},
        '{1'b1, ONES, '{64'd0, 4'd0, 32'd0, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{ONES, 4'd8, 32'hffff_ffff, 1'b1, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'h0f0f_0f0f_0f0f_0f0f, 4'd2, 32'd2, 1'b0, 1'b0}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{64'hf0f0_f0f0_f0f0_f0f0, 4'd6, 32'd0, 1'b0, 1'b1}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{ONES, 4'd0, 32'd5, 1'b0, 1'b0}, 1'b0, 64'd0},
        '{1'b0, 64'd0, '{ONES, 4'd0, 32'd0, 1'b0, 1'b1}, 1'b0, 64'd0}
    };

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    mm64_key_if  key_if ();
    mm64_hash_if hash_if ();

    murmur64a_key_hash u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_hash  (hash_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [WORD_W-1:0] pred_seed;
    logic [WORD_W-1:0] pred_hash;
    logic [WORD_W-1:0] hash_expq[$];
    int unsigned       mismatches;
    int unsigned       words_sent;
    int unsigned       burst_left;
    int unsigned       gap_max;
    int unsigned       quiet_cycles;
    int unsigned       stall_left;
    int unsigned       stall_mode;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [WORD_W-1:0] mix_word(logic [WORD_W-1:0] k);
        k = k * MIX_MUL;
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MUL;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] finish_hash(logic [WORD_W-1:0] h);
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_MUL;
        h = h ^ (h >> MIX_SHIFT);
        return h;
    endfunction

    // advance the running hash by one word, return the finished hash
    function automatic logic [WORD_W-1:0] absorb_word(t_key_beat b);
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] mask;
        int unsigned       nbytes;
        nbytes = (b.word_bytes > BYTES_PER_WORD) ? BYTES_PER_WORD : b.word_bytes;
        h = b.first_word ? (pred_seed ^ ({32'd0, b.key_length} * MIX_MUL)) : pred_hash;
        if (nbytes == BYTES_PER_WORD) begin
            h = (h ^ mix_word(b.key_word)) * MIX_MUL;
        end else if (nbytes != 0) begin
            mask = (64'd1 << (8 * nbytes)) - 64'd1;
            h = (h ^ (b.key_word & mask)) * MIX_MUL;
        end
        pred_hash = h;
        return finish_hash(h);
    endfunction

    task automatic send_word(t_key_beat b, logic fixed, logic [WORD_W-1:0] fixed_hash);
        int unsigned       gap;
        logic [WORD_W-1:0] fin;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 12);
            if (gap != 0) begin
                key_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        key_if.valid      <= 1'b1;
        key_if.key_word   <= b.key_word;
        key_if.word_bytes <= b.word_bytes;
        key_if.key_length <= b.key_length;
        key_if.first_word <= b.first_word;
        key_if.last_word  <= b.last_word;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        fin = absorb_word(b);
        if (b.last_word) begin
            hash_expq.push_back(fixed ? fixed_hash : fin);
        end
        words_sent++;
    endtask

    task automatic wait_idle();
        key_if.valid <= 1'b0;
        @(posedge i_clk);
        while (hash_expq.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pred_seed = value;
        @(posedge i_clk);
    endtask

    task automatic send_key(logic truncate);
        t_key_beat   b;
        int unsigned len;
        int unsigned nfull;
        int unsigned nwords;
        int unsigned nsend;
        logic [31:0] klen;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 40);
        klen = ($urandom_range(0, 9) == 0) ? $urandom : len;
        nfull = len / 8;
        nwords = ((len % 8) != 0 || len == 0) ? nfull + 1 : nfull;
        nsend = truncate ? $urandom_range(1, nwords) : nwords;
        for (int unsigned i = 0; i < nsend; i++) begin
            b.key_word   = {$urandom, $urandom};
            b.word_bytes = (i < nfull) ? 4'd8 : 4'(len % 8);
            if (b.word_bytes == 4'd8 && $urandom_range(0, 15) == 0) begin
                b.word_bytes = 4'($urandom_range(9, 15));
            end
            b.first_word = (i == 0);
            b.last_word  = !truncate && (i == nwords - 1);
            b.key_length = b.first_word ? klen : $urandom;
            send_word(b, 1'b0, '0);
        end
    endtask

    task automatic send_noise();
        t_key_beat b;
        b.key_word   = {$urandom, $urandom};
        b.word_bytes = 4'($urandom_range(0, 15));
        b.key_length = $urandom;
        b.first_word = 1'($urandom_range(0, 1));
        b.last_word  = 1'($urandom_range(0, 1));
        send_word(b, 1'b0, '0);
    endtask

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && hash_if.valid && hash_if.ready) begin
            if (hash_expq.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected hash transaction: %h", hash_if.hash_value);
                end
                mismatches++;
            end else begin
                if (hash_if.hash_value !== hash_expq[0]) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("hash_value mismatch: expected %h, got %h",
                                 hash_expq[0], hash_if.hash_value);
                    end
                    mismatches++;
                end
                void'(hash_expq.pop_front());
            end
        end
        if ((key_if.valid && key_if.ready) || (hash_if.valid && hash_if.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: hash_if.ready <= 1'b1;
            1: hash_if.ready <= 1'($urandom_range(0, 1));
            2: hash_if.ready <= ($urandom_range(0, 3) == 0);
            default: hash_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    initial begin
        logic [WORD_W-1:0] seed;
        int unsigned       phase_start;
        int unsigned       pick;
        words_sent   = 0;
        burst_left   = 0;
        gap_max      = 6;
        pred_seed    = SEED_RESET;
        pred_hash    = '0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        key_if.valid      = 1'b0;
        key_if.key_word   = '0;
        key_if.word_bytes = '0;
        key_if.key_length = '0;
        key_if.first_word = 1'b0;
        key_if.last_word  = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].reseed) begin
                wait_idle();
                write_seed(DIR_TABLE[i].seed);
            end
            send_word(DIR_TABLE[i].beat, DIR_TABLE[i].fixed, DIR_TABLE[i].fixed_hash);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: seed = '0;
                1: seed = ONES;
                3: seed = SEED_RESET;
                default: seed = {$urandom, $urandom};
            endcase
            write_seed(seed);
            gap_max = (phase == 2) ? 0 : $urandom_range(2, 8);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    send_noise();
                end else if (pick < 18) begin
                    send_key(1'b1);
                end else begin
                    send_key(1'b0);
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && hash_expq.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: murmur64a_key_hash.f
rtl/mm64_pkg.sv
rtl/mm64_if.sv
rtl/mm64_mul.sv
rtl/mm64_cfg.sv
rtl/mm64_ctrl.sv
rtl/murmur64a_key_hash.sv
rtl/mm64_chk.sv
test/murmur64a_key_hash_tb.sv
